[hw/rtl/bbdr_pkg.sv]
// ----------------------------------------------------------------------------
// Bounding-box diagonal radius package
// Shared constants, state type and control struct for the radius block.
// ----------------------------------------------------------------------------
`default_nettype none

package bbdr_pkg;

  // Default saturation limit of the point counter.
  localparam int unsigned MAX_POINTS_DEF = 1048576;

  // Coordinate width and the width of the total_points output field.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned TOTAL_W = 21;
  localparam int unsigned RADIUS_W = 33;

  // Bits searched by the root engine and width of its accumulators.
  localparam int unsigned ROOT_BITS = 34;
  localparam int unsigned ACC_W = 128;
  localparam int unsigned SUM_W = 66;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    ST_ACC,
    ST_DIFF,
    ST_MUL,
    ST_SQRT,
    ST_CBRT,
    ST_OUT
  } bbdr_state_t;

  // Control from the sequencer to the root engine.
  typedef struct packed {
    logic start;
    logic cube_mode;
  } root_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/bbdr_root_engine.sv]
// ----------------------------------------------------------------------------
// Root engine
// Bit-serial search for the largest r with k*r^2 <= limit (square mode) or
// k*r^3 <= limit (cube mode). Candidate powers are built incrementally with
// one shared adder; each bit steps through T1, T2, T3 and the compare.
// ----------------------------------------------------------------------------
`default_nettype none

module bbdr_root_engine #(
  parameter int unsigned K_W = 21
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire bbdr_pkg::root_ctrl_t            ctrl,
  input  wire logic [K_W-1:0]                  k,
  input  wire logic [bbdr_pkg::ACC_W-1:0]      limit,
  output logic                                 done,
  output logic [bbdr_pkg::ROOT_BITS-1:0]       root,
  output logic [bbdr_pkg::ACC_W-1:0]           cube
);
  import bbdr_pkg::*;

  localparam logic [3:0] STEP_T1    = 4'd0;
  localparam logic [3:0] STEP_T2_A  = 4'd1;
  localparam logic [3:0] STEP_T2_B  = 4'd2;
  localparam logic [3:0] STEP_T3_A  = 4'd3;
  localparam logic [3:0] STEP_T3_B  = 4'd4;
  localparam logic [3:0] STEP_T3_C  = 4'd5;
  localparam logic [3:0] STEP_T3_D  = 4'd6;
  localparam logic [3:0] STEP_T3_E  = 4'd7;
  localparam logic [3:0] STEP_CMP   = 4'd8;
  localparam logic [5:0] TOP_BIT    = 6'(ROOT_BITS - 1);

  logic             busy;
  logic             mode;
  logic [3:0]       step;
  logic [5:0]       bpos;
  logic [ACC_W-1:0] kw, lim;
  logic [ACC_W-1:0] q1, q2, q3, t1, t2, t3;
  logic [ACC_W-1:0] add_a, add_b, add_sum;
  logic [6:0]       sh1, sh2, sh3;
  logic             fits;

  // Shift amounts for b, 2b and 3b.
  assign sh1 = {1'b0, bpos};
  assign sh2 = {bpos, 1'b0};
  assign sh3 = sh1 + sh2;

  // Operand selection for the shared adder.
  always_comb begin
    add_a = t3;
    add_b = '0;
    case (step)
      STEP_T1:   begin add_a = q1; add_b = kw << sh1; end
      STEP_T2_A: begin add_a = t2; add_b = q1 << (sh1 + 7'd1); end
      STEP_T2_B: begin add_a = t2; add_b = kw << sh2; end
      STEP_T3_A: begin add_a = t3; add_b = q2 << sh1; end
      STEP_T3_B: begin add_a = t3; add_b = q2 << (sh1 + 7'd1); end
      STEP_T3_C: begin add_a = t3; add_b = q1 << sh2; end
      STEP_T3_D: begin add_a = t3; add_b = q1 << (sh2 + 7'd1); end
      STEP_T3_E: begin add_a = t3; add_b = kw << sh3; end
      default:   begin add_a = t3; add_b = '0; end
    endcase
  end

  assign add_sum = add_a + add_b;
  assign fits    = mode ? (t3 <= lim) : (t2 <= lim);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= STEP_T1;
      bpos <= TOP_BIT;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        step <= STEP_T1;
        bpos <= TOP_BIT;
      end else if (busy) begin
        if (step == STEP_CMP) begin
          step <= STEP_T1;
          if (bpos == 6'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            bpos <= bpos - 6'd1;
          end
        end else begin
          step <= step + 4'd1;
        end
      end
    end
  end

  // Accumulators and the root under construction.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mode <= ctrl.cube_mode;
      kw   <= ACC_W'(k);
      lim  <= limit;
      q1   <= '0;
      q2   <= '0;
      q3   <= '0;
      root <= '0;
    end else if (busy) begin
      case (step)
        STEP_T1: begin
          t1 <= add_sum;
          t2 <= q2;
          t3 <= q3;
        end
        STEP_T2_A, STEP_T2_B: t2 <= add_sum;
        STEP_CMP: begin
          if (fits) begin
            q1 <= t1;
            q2 <= t2;
            q3 <= t3;
            root[bpos[5:0]] <= 1'b1;
          end
        end
        default: t3 <= add_sum;
      endcase
    end
  end

  assign cube = q3;

endmodule

`default_nettype wire

[hw/rtl/bounding_box_diagonal_radius.sv]
// ----------------------------------------------------------------------------
// Bounding-box diagonal radius
// Tracks the box of a point cloud and emits diagonal / cbrt(point count).
// ----------------------------------------------------------------------------
// Points are taken one per cycle while the block waits in its accumulate state;
// after the last point the box differences are registered, the three squares
// are summed on one 32x32 multiplier, and two root passes of 34 bits follow:
// the square root of the sum, then the cube comparison. A cloud with no valid
// point goes straight to its result. No point is taken from the last point until
// the result transaction ends. Synchronous reset clears box, counter, sequencer.
`default_nettype none

module bounding_box_diagonal_radius #(
  parameter int unsigned MAX_POINTS = bbdr_pkg::MAX_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // point_x, point_y, point_z
  input  wire logic        s_tlast,  // last_point
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,  // radius, total_points, zero fill
  output logic [0:0]       m_tuser   // no_valid_points
);
  import bbdr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic signed [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] NEG_MAX = {1'b1, {(COORD_W-1){1'b0}}};

  bbdr_state_t state, state_next;

  logic signed [COORD_W-1:0] px, py, pz;
  logic signed [COORD_W-1:0] x_low, x_high, y_low, y_high, z_low, z_high;
  logic [CNT_W-1:0]          point_count, count_held;
  logic                      any_valid;
  logic                      point_ok, take;
  logic [COORD_W-1:0]        dx, dy, dz, mul_a;
  logic [2*COORD_W-1:0]      prod;
  logic [SUM_W-1:0]          sq_sum;
  logic [1:0]                mul_idx;
  logic [ACC_W-1:0]          dcube, limit;
  logic                      launch, eng_done;
  logic [ROOT_BITS-1:0]      eng_root;
  logic [ACC_W-1:0]          eng_cube;
  root_ctrl_t                ctrl;
  logic [RADIUS_W-1:0]       radius;
  logic                      no_valid;
  logic [CNT_W+TOTAL_W-1:0]  count_ext;

  assign px = s_tdata[31:0];
  assign py = s_tdata[63:32];
  assign pz = s_tdata[95:64];
  assign point_ok = (px != '0) && (py != '0) && (pz != '0);
  assign take = s_tvalid && s_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACC:  if (take && s_tlast) state_next = ST_DIFF;
      ST_DIFF: state_next = any_valid ? ST_MUL : ST_OUT;
      ST_MUL:  if (mul_idx == 2'd3) state_next = ST_SQRT;
      ST_SQRT: if (eng_done) state_next = ST_CBRT;
      ST_CBRT: if (eng_done) state_next = ST_OUT;
      ST_OUT:  if (m_tready) state_next = ST_ACC;
      default: state_next = ST_ACC;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ST_ACC:  s_tready = 1'b1;
      ST_OUT:  m_tvalid = 1'b1;
      default: begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
    end else begin
      state <= state_next;
    end
  end

  // Box, counter and control of the arithmetic sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low       <= POS_MAX;
      y_low       <= POS_MAX;
      z_low       <= POS_MAX;
      x_high      <= NEG_MAX;
      y_high      <= NEG_MAX;
      z_high      <= NEG_MAX;
      point_count <= '0;
      any_valid   <= 1'b0;
      mul_idx     <= '0;
      launch      <= 1'b0;
    end else begin
      launch <= 1'b0;
      case (state)
        ST_ACC: begin
          if (take) begin
            if (point_count < CNT_W'(MAX_POINTS)) point_count <= point_count + 1'b1;
            if (point_ok) begin
              any_valid <= 1'b1;
              if (px < x_low)  x_low  <= px;
              if (px > x_high) x_high <= px;
              if (py < y_low)  y_low  <= py;
              if (py > y_high) y_high <= py;
              if (pz < z_low)  z_low  <= pz;
              if (pz > z_high) z_high <= pz;
            end
          end
        end
        ST_DIFF: begin
          x_low       <= POS_MAX;
          y_low       <= POS_MAX;
          z_low       <= POS_MAX;
          x_high      <= NEG_MAX;
          y_high      <= NEG_MAX;
          z_high      <= NEG_MAX;
          point_count <= '0;
          any_valid   <= 1'b0;
          mul_idx     <= '0;
        end
        ST_MUL: begin
          mul_idx <= mul_idx + 2'd1;
          if (mul_idx == 2'd3) launch <= 1'b1;
        end
        ST_SQRT: if (eng_done) launch <= 1'b1;
        default: launch <= 1'b0;
      endcase
    end
  end

  // Multiplier operand for each square.
  always_comb begin
    case (mul_idx)
      2'd0:    mul_a = dx;
      2'd1:    mul_a = dy;
      default: mul_a = dz;
    endcase
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state)
      ST_DIFF: begin
        count_held <= point_count;
        dx         <= COORD_W'(x_high - x_low);
        dy         <= COORD_W'(y_high - y_low);
        dz         <= COORD_W'(z_high - z_low);
        sq_sum     <= '0;
        radius     <= '0;
        no_valid   <= ~any_valid;
      end
      ST_MUL: begin
        prod <= mul_a * mul_a;
        if (mul_idx != 2'd0) sq_sum <= sq_sum + SUM_W'(prod);
      end
      ST_SQRT: if (eng_done) dcube <= eng_cube;
      ST_CBRT: if (eng_done) radius <= eng_root[RADIUS_W-1:0];
      default: ;
    endcase
  end

  // Engine control: square root of the sum, then the cube comparison.
  assign ctrl.start     = launch;
  assign ctrl.cube_mode = (state == ST_CBRT);
  assign limit          = (state == ST_CBRT) ? dcube : ACC_W'(sq_sum);

  bbdr_root_engine #(
    .K_W (CNT_W)
  ) u_root (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .k     ((state == ST_CBRT) ? count_held : CNT_W'(1)),
    .limit (limit),
    .done  (eng_done),
    .root  (eng_root),
    .cube  (eng_cube)
  );

  // Result transaction.
  assign count_ext = {{TOTAL_W{1'b0}}, count_held};
  assign m_tdata   = {2'b00, count_ext[TOTAL_W-1:0], radius};
  assign m_tuser   = no_valid;

endmodule

`default_nettype wire
